/* rtl/core/csvfs_pkg.sv */
package csvfs_pkg;

   localparam int CHAR_W      = 8;
   localparam int HELD_DEPTH  = 16;
   localparam int QUEUE_DEPTH = 2;   // power of two, pointers wrap naturally

   localparam logic [CHAR_W-1:0] QUOTE_CH = 8'h22;
   localparam logic [CHAR_W-1:0] COMMA_CH = 8'h2C;

   typedef enum logic [1:0] {
      OP_CHAR      = 2'd0,
      OP_SPACE     = 2'd1,
      OP_FIELD_END = 2'd2,
      OP_LINE_END  = 2'd3
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [CHAR_W-1:0] ch;
      logic              mal;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } push_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } pop_type;

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
   endfunction

endpackage

/* rtl/core/csvfs_if.sv */
interface csvfs_req_if;
   import csvfs_pkg::*;
   logic              valid;
   logic              ready;
   logic              kind;
   logic [CHAR_W-1:0] char_code;

   modport source (output valid, output kind, output char_code, input ready);
   modport sink   (input valid, input kind, input char_code, output ready);
endinterface

interface csvfs_rsp_if;
   import csvfs_pkg::*;
   logic              valid;
   logic              ready;
   logic              out_kind;
   logic [CHAR_W-1:0] field_char;
   logic              line_done;
   logic              malformed;
   logic              space_overflow;
   logic              last;

   modport source (output valid, output out_kind, output field_char, output line_done,
                   output malformed, output space_overflow, output last, input ready);
   modport sink   (input valid, input out_kind, input field_char, input line_done,
                   input malformed, input space_overflow, input last, output ready);
endinterface

/* rtl/core/csvfs_front.sv */
module csvfs_front (
   input  logic               clock,
   input  logic               reset,
   csvfs_req_if.sink          req_ch,
   input  logic               queue_full,
   output csvfs_pkg::push_type push
);
   import csvfs_pkg::*;

   logic quoting_ff, quoting_in;
   logic pending_ff, pending_in;
   logic accept;
   logic is_q, is_comma, q_eff;
   logic cmd_valid;
   cmd_type cmd;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_q         = (req_ch.char_code == QUOTE_CH);
   assign is_comma     = (req_ch.char_code == COMMA_CH);
   // a pending quote followed by anything but a quote closes the quoted span
   assign q_eff        = quoting_ff && !pending_ff;

   always_comb begin
      quoting_in = quoting_ff;
      pending_in = pending_ff;
      cmd_valid  = 1'b0;
      cmd.op     = OP_CHAR;
      cmd.ch     = req_ch.char_code;
      cmd.mal    = 1'b0;
      if (req_ch.kind) begin
         cmd_valid  = 1'b1;
         cmd.op     = OP_LINE_END;
         cmd.mal    = q_eff;
         quoting_in = 1'b0;
         pending_in = 1'b0;
      end else if (pending_ff && is_q) begin
         // doubled quote: literal quote, stay in quotes
         cmd_valid  = 1'b1;
         pending_in = 1'b0;
      end else begin
         pending_in = 1'b0;
         quoting_in = q_eff;
         if (is_q) begin
            if (q_eff) begin
               pending_in = 1'b1;
            end else begin
               quoting_in = 1'b1;
            end
         end else if (is_comma && !q_eff) begin
            cmd_valid = 1'b1;
            cmd.op    = OP_FIELD_END;
         end else begin
            cmd_valid = 1'b1;
            cmd.op    = is_space(req_ch.char_code) ? OP_SPACE : OP_CHAR;
         end
      end
   end

   assign push.valid = accept && cmd_valid;
   assign push.cmd   = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         quoting_ff <= 1'b0;
         pending_ff <= 1'b0;
      end else if (accept) begin
         quoting_ff <= quoting_in;
         pending_ff <= pending_in;
      end
   end

endmodule

/* rtl/core/csvfs_queue.sv */
module csvfs_queue (
   input  logic               clock,
   input  logic               reset,
   input  csvfs_pkg::push_type push,
   output logic               full,
   output csvfs_pkg::pop_type  head,
   input  logic               pop
);
   import csvfs_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

/* rtl/core/csvfs_back.sv */
module csvfs_back #(
   parameter int HELD_DEPTH = csvfs_pkg::HELD_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  csvfs_pkg::pop_type head,
   output logic              pop,
   csvfs_rsp_if.source       rsp_ch
);
   import csvfs_pkg::*;

   localparam int ADDR_W = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
   localparam int CNT_W  = $clog2(HELD_DEPTH + 1);

   typedef enum logic [1:0] {
      BACK_IDLE  = 2'b01,
      BACK_FLUSH = 2'b10
   } back_state_type;

   back_state_type    state_ff, state_in;
   logic              started_ff, started_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              ovf_ff, ovf_in;
   logic [CHAR_W-1:0] cur_ch_ff, cur_ch_in;

   logic [CHAR_W-1:0] held_mem [HELD_DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;
   logic              mem_we, rd_en;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic              out_kind_ff, out_done_ff, out_mal_ff, out_ovf_ff, out_last_ff;
   logic [CHAR_W-1:0] out_ch_ff;
   logic              out_mem_ff;
   logic              out_load;
   logic              ld_kind, ld_done, ld_mal, ld_ovf, ld_last, ld_mem;
   logic [CHAR_W-1:0] ld_ch;
   logic              out_free;

   assign out_free = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in   = state_ff;
      started_in = started_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      ovf_in     = ovf_ff;
      cur_ch_in  = cur_ch_ff;
      pop        = 1'b0;
      mem_we     = 1'b0;
      rd_en      = 1'b0;
      out_load   = 1'b0;
      ld_kind    = 1'b0;
      ld_ch      = '0;
      ld_done    = 1'b0;
      ld_mal     = 1'b0;
      ld_ovf     = ovf_ff;
      ld_last    = 1'b0;
      ld_mem     = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            if (head.valid && out_free) begin
               pop = 1'b1;
               case (head.cmd.op)
                  OP_SPACE: begin
                     if (started_ff) begin
                        if (count_ff < CNT_W'(HELD_DEPTH)) begin
                           mem_we   = 1'b1;
                           count_in = count_ff + 1'b1;
                        end else begin
                           ovf_in = 1'b1;
                        end
                     end
                  end
                  OP_CHAR: begin
                     if (count_ff == '0) begin
                        out_load   = 1'b1;
                        ld_ch      = head.cmd.ch;
                        ld_last    = 1'b1;
                        started_in = 1'b1;
                     end else begin
                        cur_ch_in = head.cmd.ch;
                        idx_in    = '0;
                        state_in  = BACK_FLUSH;
                     end
                  end
                  OP_FIELD_END: begin
                     out_load   = 1'b1;
                     ld_kind    = 1'b1;
                     ld_last    = 1'b1;
                     started_in = 1'b0;
                     count_in   = '0;
                  end
                  OP_LINE_END: begin
                     out_load   = 1'b1;
                     ld_kind    = 1'b1;
                     ld_done    = 1'b1;
                     ld_mal     = head.cmd.mal;
                     ld_last    = 1'b1;
                     started_in = 1'b0;
                     count_in   = '0;
                     ovf_in     = 1'b0;
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         BACK_FLUSH: begin
            if (out_free) begin
               out_load = 1'b1;
               if (idx_ff < count_ff) begin
                  rd_en  = 1'b1;
                  ld_mem = 1'b1;
                  idx_in = idx_ff + 1'b1;
               end else begin
                  ld_ch      = cur_ch_ff;
                  ld_last    = 1'b1;
                  count_in   = '0;
                  started_in = 1'b1;
                  state_in   = BACK_IDLE;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
      out_valid_in = out_load || (out_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         started_ff   <= 1'b0;
         count_ff     <= '0;
         idx_ff       <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ch_ff <= cur_ch_in;
      if (out_load) begin
         out_kind_ff <= ld_kind;
         out_ch_ff   <= ld_ch;
         out_done_ff <= ld_done;
         out_mal_ff  <= ld_mal;
         out_ovf_ff  <= ld_ovf;
         out_last_ff <= ld_last;
         out_mem_ff  <= ld_mem;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         held_mem[count_ff[ADDR_W-1:0]] <= head.cmd.ch;
      end
      if (rd_en) begin
         rd_data_ff <= held_mem[idx_ff[ADDR_W-1:0]];
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.out_kind       = out_kind_ff;
   assign rsp_ch.field_char     = out_mem_ff ? rd_data_ff : out_ch_ff;
   assign rsp_ch.line_done      = out_done_ff;
   assign rsp_ch.malformed      = out_mal_ff;
   assign rsp_ch.space_overflow = out_ovf_ff;
   assign rsp_ch.last           = out_last_ff;

endmodule

/* rtl/core/csv_field_splitter.sv */
// CSV field splitter: takes one line one byte per request, with an end-of-line
// request closing it, and returns the trimmed characters of each field followed
// by an end-of-field result; quotes, doubled quotes and commas inside quotes
// follow the usual CSV rules. The front end classifies each request
// combinationally and hands it to a two-entry queue, so requests are taken at
// one per cycle while the queue has room. The result side pops a request when
// its result register is free; a content character after held trailing
// whitespace bytes enters a replay that returns each held byte from the
// HELD_DEPTH-entry store before it, and the queue fills and stalls the request
// side during such a burst. Quote characters give no result but the second of
// a doubled quote, nor does leading whitespace. Whitespace beyond HELD_DEPTH
// held bytes is dropped and space_overflow stays set until the end of the line.
module csv_field_splitter #(
   parameter int HELD_DEPTH = csvfs_pkg::HELD_DEPTH
) (
   input logic         clock,
   input logic         reset,
   csvfs_req_if.sink   req_ch,
   csvfs_rsp_if.source rsp_ch
);
   import csvfs_pkg::*;

   push_type push;
   pop_type  head;
   logic     queue_full;
   logic     pop;

   csvfs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push)
   );

   csvfs_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   csvfs_back #(
      .HELD_DEPTH (HELD_DEPTH)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

/* sim/tb.sv */
module tb;
   import csvfs_pkg::*;

   localparam logic KIND_CHAR     = 1'b0;
   localparam logic KIND_EOL      = 1'b1;
   localparam logic OUT_CHAR      = 1'b0;
   localparam logic OUT_FIELD_END = 1'b1;
   localparam int   RANDOM_ITEMS  = 135;
   localparam int   LONG_HOLD     = 400;
   localparam int   STALL_LIMIT   = 4000;
   localparam int   DRAIN_CYCLES  = 40;

   typedef struct packed {
      logic              kind;
      logic [CHAR_W-1:0] ch;
   } line_byte_type;

   typedef struct packed {
      logic              out_kind;
      logic [CHAR_W-1:0] field_char;
      logic              line_done;
      logic              malformed;
      logic              space_overflow;
      logic              last;
   } split_result_type;

   logic clock;
   logic reset;

   csvfs_req_if req_if ();
   csvfs_rsp_if rsp_if ();

   csv_field_splitter DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source)
   );

   line_byte_type    pending_bytes[$];
   split_result_type expected_fields[$];
   split_result_type step_out[$];

   // splitter state as predicted
   logic              in_quotes;
   logic              quote_held;
   logic              field_open;
   logic [CHAR_W-1:0] blank_store[HELD_DEPTH];
   int                blank_count;
   logic              spill_seen;

   int fail_count;
   int req_count;
   int rsp_count;
   int lines_closed;
   int malformed_lines;
   int overflow_lines;
   int longest_burst;
   int burst_left;
   int gap_left;
   int hold_left;
   int rx_cycle;
   int rx_mode;
   bit long_hold_done;
   int idle_cycles;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------- predictor ----------------
   function automatic bit is_blank(input logic [CHAR_W-1:0] c);
      return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
   endfunction

   function void put_result(input logic k, input logic [CHAR_W-1:0] c,
                            input logic done, input logic mal);
      split_result_type r;
      r.out_kind       = k;
      r.field_char     = c;
      r.line_done      = done;
      r.malformed      = mal;
      r.space_overflow = spill_seen;
      r.last           = 1'b0;
      step_out.insert(step_out.size(), r);
   endfunction

   function void add_content(input logic [CHAR_W-1:0] c);
      if (is_blank(c)) begin
         // leading blanks vanish, trailing ones wait for more content
         if (field_open) begin
            if (blank_count < HELD_DEPTH) begin
               blank_store[blank_count] = c;
               blank_count++;
            end else begin
               spill_seen = 1'b1;
            end
         end
      end else begin
         for (int i = 0; i < blank_count; i++)
            put_result(OUT_CHAR, blank_store[i], 1'b0, 1'b0);
         blank_count = 0;
         field_open  = 1'b1;
         put_result(OUT_CHAR, c, 1'b0, 1'b0);
      end
   endfunction

   function void predict_split(input logic kind, input logic [CHAR_W-1:0] c);
      split_result_type r;
      bit               handled;
      step_out.delete();
      handled = 1'b0;
      if (kind == KIND_EOL) begin
         if (quote_held) begin
            quote_held = 1'b0;
            in_quotes  = 1'b0;
         end
         put_result(OUT_FIELD_END, 8'd0, 1'b1, in_quotes);
         lines_closed++;
         if (in_quotes) malformed_lines++;
         if (spill_seen) overflow_lines++;
         in_quotes   = 1'b0;
         field_open  = 1'b0;
         blank_count = 0;
         spill_seen  = 1'b0;
      end else begin
         if (quote_held) begin
            quote_held = 1'b0;
            if (c == QUOTE_CH) begin
               add_content(c);
               handled = 1'b1;
            end else begin
               in_quotes = 1'b0;
            end
         end
         if (!handled) begin
            if (c == QUOTE_CH) begin
               if (in_quotes) quote_held = 1'b1;
               else in_quotes = 1'b1;
            end else if (c == COMMA_CH && !in_quotes) begin
               put_result(OUT_FIELD_END, 8'd0, 1'b0, 1'b0);
               field_open  = 1'b0;
               blank_count = 0;
            end else begin
               add_content(c);
            end
         end
      end
      if (step_out.size() > longest_burst) longest_burst = step_out.size();
      foreach (step_out[i]) begin
         r      = step_out[i];
         r.last = (i == step_out.size() - 1);
         expected_fields.insert(expected_fields.size(), r);
      end
   endfunction

   // ---------------- stimulus helpers ----------------
   function void push_item(input logic kind, input logic [CHAR_W-1:0] c);
      line_byte_type b;
      b.kind = kind;
      b.ch   = c;
      pending_bytes.insert(pending_bytes.size(), b);
   endfunction

   function void push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         push_item(KIND_CHAR, s[i]);
   endfunction

   function void push_eol();
      push_item(KIND_EOL, 8'($urandom_range(0, 255)));
   endfunction

   function automatic logic [CHAR_W-1:0] pick_blank();
      int n;
      n = $urandom_range(0, 5);
      return (n == 5) ? 8'd32 : 8'(9 + n);
   endfunction

   function automatic logic [CHAR_W-1:0] pick_plain();
      logic [CHAR_W-1:0] c;
      do
         c = 8'($urandom_range(0, 255));
      while (is_blank(c) || c == QUOTE_CH || c == COMMA_CH);
      return c;
   endfunction

   function automatic void add_random_line();
      int fields;
      int len;
      int run;
      bit quoted;
      if ($urandom_range(0, 9) == 0) begin
         // noise line
         repeat ($urandom_range(1, 12)) push_item(KIND_CHAR, 8'($urandom_range(0, 255)));
      end else begin
         fields = $urandom_range(1, 4);
         for (int f = 0; f < fields; f++) begin
            if (f != 0) push_item(KIND_CHAR, COMMA_CH);
            repeat ($urandom_range(0, 2)) push_item(KIND_CHAR, pick_blank());
            quoted = ($urandom_range(0, 2) == 0);
            if (quoted) push_item(KIND_CHAR, QUOTE_CH);
            len = $urandom_range(0, 6);
            for (int k = 0; k < len; k++) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: push_item(KIND_CHAR, pick_plain());
                  5, 6: begin
                     run = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20)
                                                       : $urandom_range(1, 3);
                     repeat (run) push_item(KIND_CHAR, pick_blank());
                  end
                  7: push_item(KIND_CHAR, quoted ? COMMA_CH : pick_plain());
                  8: begin
                     if (quoted) begin
                        push_item(KIND_CHAR, QUOTE_CH);
                        push_item(KIND_CHAR, QUOTE_CH);
                     end else begin
                        push_item(KIND_CHAR, pick_blank());
                     end
                  end
                  default: push_item(KIND_CHAR, 8'($urandom_range(0, 255)));
               endcase
            end
            // now and then leave the quote open
            if (quoted && $urandom_range(0, 7) != 0) push_item(KIND_CHAR, QUOTE_CH);
            if ($urandom_range(0, 2) == 0)
               repeat ($urandom_range(1, 3)) push_item(KIND_CHAR, pick_blank());
         end
      end
      push_eol();
   endfunction

   // ---------------- request driver ----------------
   always @(posedge clock) begin
      line_byte_type b;
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left   = $urandom_range(1, 30);
         gap_left     = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_split(req_if.kind, req_if.char_code);
            req_count++;
         end
         if (!(req_if.valid && !req_if.ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               b = pending_bytes.pop_front();
               req_if.valid     <= 1'b1;
               req_if.kind      <= b.kind;
               req_if.char_code <= b.ch;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 30);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- result receiver ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left    = 0;
         rx_cycle     = 0;
         rx_mode      = 0;
      end else begin
         rx_cycle++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (!long_hold_done && req_count >= 40) begin
            // long back-pressure so the internal queue fills up
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            if (rx_cycle % 50 == 0) rx_mode = $urandom_range(0, 3);
            case (rx_mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= 1'($urandom_range(0, 1));
               2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_if.ready <= (rx_cycle % 3 != 0);
            endcase
         end
      end
   end

   // ---------------- result checker ----------------
   function void check_field(input string name, input logic [CHAR_W-1:0] want,
                             input logic [CHAR_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      split_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         rsp_count++;
         if (expected_fields.size() == 0) begin
            $error("result with no request waiting for it");
            fail_count++;
         end else begin
            want = expected_fields.pop_front();
            check_field("out_kind", 8'(want.out_kind), 8'(rsp_if.out_kind));
            check_field("field_char", want.field_char, rsp_if.field_char);
            check_field("line_done", 8'(want.line_done), 8'(rsp_if.line_done));
            check_field("malformed", 8'(want.malformed), 8'(rsp_if.malformed));
            check_field("space_overflow", 8'(want.space_overflow),
                        8'(rsp_if.space_overflow));
            check_field("last", 8'(want.last), 8'(rsp_if.last));
         end
      end
   end

   // ---------------- watchdog ----------------
   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("no handshake for %0d cycles, %0d results still expected",
               STALL_LIMIT, expected_fields.size());
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------- main sequence ----------------
   initial begin
      int random_items;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.kind      = 1'b0;
      req_if.char_code = '0;
      rsp_if.ready     = 1'b0;
      in_quotes        = 1'b0;
      quote_held       = 1'b0;
      field_open       = 1'b0;
      blank_count      = 0;
      spill_seen       = 1'b0;
      fail_count       = 0;
      req_count        = 0;
      rsp_count        = 0;
      lines_closed     = 0;
      malformed_lines  = 0;
      overflow_lines   = 0;
      longest_burst    = 0;
      long_hold_done   = 1'b0;

      // leading blanks, quoted comma, doubled quote, quote closed by a blank,
      // held tab dropped at the comma, zero and all-ones bytes as content
      push_text(" \t\"a,\"\"b\" c\t,");
      push_item(KIND_CHAR, 8'h00);
      push_item(KIND_CHAR, 8'hFF);
      push_eol();
      // closing quote decided by end of line: not malformed
      push_text("\"q\"");
      push_eol();
      // quote still open at end of line
      push_text("\"o");
      push_eol();

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         int size_was;
         size_was = pending_bytes.size();
         add_random_line();
         random_items += pending_bytes.size() - size_was;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_if.valid) @(posedge clock);
      while (expected_fields.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests over %0d lines", req_count, lines_closed);
      $display("(%0d with an open quote, %0d with held-blank overflow)",
               malformed_lines, overflow_lines);
      $display("%0d results checked, largest burst from one request: %0d",
               rsp_count, longest_burst);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
